>>> rtl/core/abna_pkg.sv
package abna_pkg;

    localparam logic [63:0] LOW48_MASK  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] HIGH16_MASK = 64'hFFFF_0000_0000_0000;

    localparam int unsigned FIT_STAGES   = 8;
    localparam int unsigned FIT_PER_STEP = 8;

    // width select codes
    localparam logic [1:0] WSEL_AUTO = 2'd0;
    localparam logic [1:0] WSEL_48   = 2'd1;
    localparam logic [1:0] WSEL_64   = 2'd2;

    // slap classes
    localparam logic [1:0] SLAP_NONE = 2'd0;
    localparam logic [1:0] SLAP_ELI  = 2'd1;
    localparam logic [1:0] SLAP_SAI  = 2'd2;
    localparam logic [1:0] SLAP_AAI  = 2'd3;

    localparam logic [2:0] ZYX_ELI = 3'b101;
    localparam logic [2:0] ZYX_SAI = 3'b111;
    localparam logic [2:0] ZYX_AAI = 3'b001;

    typedef struct packed {
        logic [63:0] addr;
        logic [63:0] val;
        logic [63:0] hi;
        logic [63:0] mask;
        logic        is_mask;
        logic        want_mask;
        logic        wide;
        logic        empty;
    } t_item;

    typedef struct packed {
        logic        empty_flag;
        logic        multicast_flag;
        logic        local_flag;
        logic [1:0]  slap_class;
        logic        is_wide;
        logic        result_is_mask;
        logic [63:0] aligned_value;
        logic [63:0] aligned_base;
    } t_result;

    // low j ones in a 65-bit word, j from 1 to 64
    function automatic logic [64:0] f_ones(input int unsigned j);
        logic [65:0] v;
        v = (66'd1 << j) - 66'd1;
        return v[64:0];
    endfunction

endpackage

>>> rtl/core/address_block_normalize_align_core.sv
// channel | dir | bits | contents
// s       | in  | 136  | tdata: base_addr, set_value, value_is_mask, width_sel, target_is_mask
// m       | out | 136  | tdata: aligned_base, aligned_value, result_is_mask, is_wide,
//         |     |      |        slap_class, local_flag, multicast_flag, empty_flag
//
// one transaction per cycle sustained while m takes results, through ten register stages:
// normalize stage, eight fit stages testing eight block sizes each, one finish/output
// stage; the result passes through these stage registers in order on its way to m
// synchronous active-low reset clears the stage valid bits only
// a stall on m holds every stage together; s_tready drops only while the
// output register is full and not taken
module address_block_normalize_align_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // base_addr, set_value, value_is_mask, width_sel, target_is_mask
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata   // aligned_base, aligned_value, result_is_mask, is_wide,
                                     // slap_class, local_flag, multicast_flag, empty_flag
);

    logic              en;
    logic              valid [abna_pkg::FIT_STAGES + 1];
    abna_pkg::t_item   item  [abna_pkg::FIT_STAGES + 1];
    logic              out_valid;
    abna_pkg::t_result result;

    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = en;

    abna_norm u_norm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_s_tvalid),
        .i_base_addr      (i_s_tdata[63:0]),
        .i_set_value      (i_s_tdata[127:64]),
        .i_value_is_mask  (i_s_tdata[128]),
        .i_width_sel      (i_s_tdata[130:129]),
        .i_target_is_mask (i_s_tdata[131]),
        .o_valid          (valid[0]),
        .o_item           (item[0])
    );

    for (genvar g = 0; g < abna_pkg::FIT_STAGES; g++) begin : g_fit
        abna_fit_stage #(.STAGE(g)) u_fit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (valid[g]),
            .i_item  (item[g]),
            .o_valid (valid[g + 1]),
            .o_item  (item[g + 1])
        );
    end

    abna_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (valid[abna_pkg::FIT_STAGES]),
        .i_item   (item[abna_pkg::FIT_STAGES]),
        .o_valid  (out_valid),
        .o_result (result)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {1'b0, result};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && result.empty_flag |-> result.aligned_value == 64'd0)
        else $error("empty result with nonzero value");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !i_m_tready |=> out_valid && $stable(result))
        else $error("output changed under stall");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!out_valid || i_m_tready))
        else $error("input ready out of step with output stage");

endmodule

>>> rtl/core/abna_norm.sv
module abna_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_base_addr,
    input  logic [63:0]         i_set_value,
    input  logic                i_value_is_mask,
    input  logic [1:0]          i_width_sel,
    input  logic                i_target_is_mask,
    output logic                o_valid,
    output abna_pkg::t_item     o_item
);

    logic            r_valid;
    abna_pkg::t_item r_item;
    abna_pkg::t_item n_item;
    logic [64:0]     sum;

    always_comb begin
        n_item           = '0;
        n_item.is_mask   = i_value_is_mask;
        n_item.want_mask = i_target_is_mask;
        case (i_width_sel)
            abna_pkg::WSEL_48: n_item.wide = 1'b0;
            abna_pkg::WSEL_64: n_item.wide = 1'b1;
            default:           n_item.wide = i_base_addr > abna_pkg::LOW48_MASK;
        endcase
        n_item.addr = i_value_is_mask ? (i_base_addr & i_set_value) : i_base_addr;
        n_item.val  = i_set_value;
        if (!n_item.wide) begin
            n_item.addr = n_item.addr & abna_pkg::LOW48_MASK;
            if (i_value_is_mask) begin
                n_item.val = i_set_value | abna_pkg::HIGH16_MASK;
            end
        end
        n_item.empty = !i_value_is_mask && (i_set_value == 64'd0);
        // range end, saturating at the top of the space
        sum = {1'b0, n_item.addr} + {1'b0, i_set_value - 64'd1};
        n_item.hi   = sum[64] ? '1 : sum[63:0];
        n_item.mask = '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/abna_fit_stage.sv
module abna_fit_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  abna_pkg::t_item     i_item,
    output logic                o_valid,
    output abna_pkg::t_item     o_item
);

    logic            r_valid;
    abna_pkg::t_item r_item;
    abna_pkg::t_item n_item;
    logic [64:0]     ones;
    logic [64:0]     first;
    logic [63:0]     last;

    // block of size 2^j fits when the rounded-up start does not wrap
    // and its last address stays within the range end
    always_comb begin
        n_item = i_item;
        ones   = '0;
        first  = '0;
        last   = '0;
        for (int unsigned k = 0; k < abna_pkg::FIT_PER_STEP; k++) begin
            ones  = abna_pkg::f_ones(STAGE * abna_pkg::FIT_PER_STEP + k + 1);
            first = ({1'b0, i_item.addr} + ones) & ~ones;
            last  = first[63:0] | ones[63:0];
            n_item.mask[STAGE * abna_pkg::FIT_PER_STEP + k] =
                first[64] || (last > i_item.hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/abna_finish.sv
module abna_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  abna_pkg::t_item     i_item,
    output logic                o_valid,
    output abna_pkg::t_result   o_result
);

    logic              r_valid;
    abna_pkg::t_result r_result;
    abna_pkg::t_result n_result;
    logic [63:0]       base_al;
    logic [3:0]        nib;

    always_comb begin
        n_result                = '0;
        n_result.result_is_mask = i_item.want_mask;
        n_result.is_wide        = i_item.wide;
        n_result.empty_flag     = i_item.empty;
        base_al = (i_item.addr + ~i_item.mask) & i_item.mask;
        if (i_item.is_mask) begin
            n_result.aligned_base  = i_item.addr;
            // lowest set bit is two to the trailing zero count
            n_result.aligned_value = i_item.want_mask ? i_item.val
                                   : (i_item.val & (~i_item.val + 64'd1));
        end else if (i_item.empty) begin
            n_result.aligned_base  = i_item.addr;
            n_result.aligned_value = '0;
        end else begin
            n_result.aligned_base  = base_al;
            n_result.aligned_value = i_item.want_mask ? i_item.mask
                                   : (~i_item.mask + 64'd1);
        end
        nib = i_item.wide ? n_result.aligned_base[59:56] : n_result.aligned_base[43:40];
        n_result.local_flag     = nib[1];
        n_result.multicast_flag = nib[0];
        case (nib[3:1])
            abna_pkg::ZYX_ELI: n_result.slap_class = abna_pkg::SLAP_ELI;
            abna_pkg::ZYX_SAI: n_result.slap_class = abna_pkg::SLAP_SAI;
            abna_pkg::ZYX_AAI: n_result.slap_class = abna_pkg::SLAP_AAI;
            default:           n_result.slap_class = abna_pkg::SLAP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> test/address_block_normalize_align_core_tb.sv
module address_block_normalize_align_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        target_is_mask;
        logic [1:0]  width_sel;
        logic        value_is_mask;
        logic [63:0] set_value;
        logic [63:0] base_addr;
    } t_req;

    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [135:0] o_m_tdata;

    t_req                 pending_reqs[$];
    abna_pkg::t_result    expected_blocks[$];
    int unsigned mismatch_count = 0;
    int unsigned accepted_in = 0;
    int unsigned accepted_out = 0;
    int unsigned idle_cycles = 0;
    logic        quiet_mode = 1'b0;
    logic        hold_sink = 1'b0;
    logic        hold_source = 1'b0;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    int unsigned empty_seen = 0;
    logic        in_taken = 1'b0;

    address_block_normalize_align_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned trailing_zeros(input logic [63:0] m);
        int unsigned n;
        n = 0;
        while (n < 64 && m[n] == 1'b0) n++;
        return n;
    endfunction

    // widen the block one bit at a time while it still fits in [lo, hi]
    function automatic logic [63:0] fit_block_mask(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] m;
        logic [63:0] nm;
        logic [63:0] f;
        logic [63:0] l;
        m = '1;
        for (int i = 0; i < 64; i++) begin
            nm = m << 1;
            f = (lo + ~nm) & nm;
            l = f + ~nm;
            if (f < lo || l > hi) break;
            m = nm;
        end
        return m;
    endfunction

    function automatic abna_pkg::t_result align_block(input t_req r);
        abna_pkg::t_result res;
        logic [63:0] addr;
        logic [63:0] val;
        logic [63:0] hi;
        logic [63:0] m;
        logic        wide;
        logic [3:0]  nib;
        logic [2:0]  zyx;
        res = '0;
        addr = r.base_addr;
        val = r.set_value;
        if (r.width_sel == abna_pkg::WSEL_48) wide = 1'b0;
        else if (r.width_sel == abna_pkg::WSEL_64) wide = 1'b1;
        else wide = addr > abna_pkg::LOW48_MASK;
        if (r.value_is_mask) addr &= val;
        if (!wide) begin
            addr &= abna_pkg::LOW48_MASK;
            if (r.value_is_mask) val |= abna_pkg::HIGH16_MASK;
        end
        if (r.value_is_mask) begin
            if (!r.target_is_mask) begin
                if (trailing_zeros(val) >= 64) val = '0;
                else val = 64'd1 << trailing_zeros(val);
            end
        end else if (val == '0) begin
            res.empty_flag = 1'b1;
        end else begin
            hi = addr + (val - 64'd1);
            if (hi < addr) hi = '1;
            m = fit_block_mask(addr, hi);
            addr = (addr + ~m) & m;
            val = r.target_is_mask ? m : (~m + 64'd1);
        end
        nib = wide ? addr[59:56] : addr[43:40];
        zyx = nib[3:1];
        if (zyx == abna_pkg::ZYX_ELI) res.slap_class = abna_pkg::SLAP_ELI;
        else if (zyx == abna_pkg::ZYX_SAI) res.slap_class = abna_pkg::SLAP_SAI;
        else if (zyx == abna_pkg::ZYX_AAI) res.slap_class = abna_pkg::SLAP_AAI;
        else res.slap_class = abna_pkg::SLAP_NONE;
        res.aligned_base = addr;
        res.aligned_value = val;
        res.result_is_mask = r.target_is_mask;
        res.is_wide = wide;
        res.local_flag = nib[1];
        res.multicast_flag = nib[0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // prefix mask: ones from the top down to a random bit
    function automatic logic [63:0] rand_prefix();
        int unsigned tz;
        tz = $urandom_range(0, 64);
        return (tz == 64) ? 64'd0 : ({64{1'b1}} << tz);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.base_addr = rand64();
        case ($urandom_range(0, 3))
            0: r.base_addr &= abna_pkg::LOW48_MASK;
            1: r.base_addr = rand64() >> $urandom_range(0, 63);
            default: ;
        endcase
        r.value_is_mask = 1'($urandom_range(0, 1));
        if (r.value_is_mask) begin
            r.set_value = ($urandom_range(0, 7) == 0) ? rand64() : rand_prefix();
        end else begin
            case ($urandom_range(0, 5))
                0: r.set_value = rand64();
                1: r.set_value = '0;
                2: r.set_value = 64'd1 << $urandom_range(0, 63);
                default: r.set_value = rand64() >> $urandom_range(1, 63);
            endcase
        end
        r.width_sel = 2'($urandom_range(0, 3));
        r.target_is_mask = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_req make_req(input logic [63:0] b, input logic [63:0] v,
                                      input logic vm, input logic [1:0] ws, input logic tm);
        t_req r;
        r.base_addr = b;
        r.set_value = v;
        r.value_is_mask = vm;
        r.width_sel = ws;
        r.target_is_mask = tm;
        return r;
    endfunction

    // input transaction taken at the last rising edge
    always @(posedge i_clk) in_taken <= i_s_tvalid && o_s_tready;

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
            // hold the offered transaction
        end else begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (hold_source || pending_reqs.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 6);
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tdata <= {4'b0, pending_reqs.pop_front()};
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // sink stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            i_m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            snk_gap <= $urandom_range(0, 6);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        abna_pkg::t_result got;
        abna_pkg::t_result exp_r;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_blocks.push_back(align_block(t_req'(i_s_tdata[131:0])));
                accepted_in <= accepted_in + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = abna_pkg::t_result'(o_m_tdata[134:0]);
                accepted_out <= accepted_out + 1;
                if (got.empty_flag) empty_seen <= empty_seen + 1;
                if (expected_blocks.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result transaction: %h", o_m_tdata);
                end else begin
                    exp_r = expected_blocks.pop_front();
                    if (got !== exp_r) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10) begin
                            $display("mismatch: base exp %h got %h, value exp %h got %h",
                                     exp_r.aligned_base, got.aligned_base,
                                     exp_r.aligned_value, got.aligned_value);
                            $display("  flags exp m%0b w%0b c%0d l%0b mc%0b e%0b",
                                     exp_r.result_is_mask, exp_r.is_wide, exp_r.slap_class,
                                     exp_r.local_flag, exp_r.multicast_flag, exp_r.empty_flag);
                            $display("  flags got m%0b w%0b c%0d l%0b mc%0b e%0b",
                                     got.result_is_mask, got.is_wide, got.slap_class,
                                     got.local_flag, got.multicast_flag, got.empty_flag);
                        end
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_s_tvalid || expected_blocks.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        pending_reqs.push_back(make_req('0, '0, 1'b0, abna_pkg::WSEL_AUTO, 1'b0));
        pending_reqs.push_back(make_req('0, '0, 1'b0, abna_pkg::WSEL_64, 1'b1));
        pending_reqs.push_back(make_req('1, '1, 1'b0, abna_pkg::WSEL_AUTO, 1'b0));
        pending_reqs.push_back(make_req('1, '1, 1'b0, abna_pkg::WSEL_64, 1'b1));
        pending_reqs.push_back(make_req('1, 64'd1, 1'b0, 2'd3, 1'b1));
        pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF, 64'd5, 1'b0,
                                        abna_pkg::WSEL_AUTO, 1'b0));
        pending_reqs.push_back(make_req(64'h1_0000_0000_0000, 64'd16, 1'b0,
                                        abna_pkg::WSEL_AUTO, 1'b1));
        pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFF0, 64'd100, 1'b0,
                                        abna_pkg::WSEL_64, 1'b0));
        pending_reqs.push_back(make_req(64'h0000_0000_0000_0003, 64'd13, 1'b0,
                                        abna_pkg::WSEL_48, 1'b0));
        pending_reqs.push_back(make_req(64'h1234_5678_9ABC_DEF0, '0, 1'b1,
                                        abna_pkg::WSEL_64, 1'b0));
        pending_reqs.push_back(make_req(64'h1234_5678_9ABC_DEF0, '0, 1'b1,
                                        abna_pkg::WSEL_48, 1'b0));
        pending_reqs.push_back(make_req('1, '1, 1'b1, abna_pkg::WSEL_AUTO, 1'b0));
        pending_reqs.push_back(make_req('1, 64'hFFFF_FFFF_FFFF_F000, 1'b1,
                                        abna_pkg::WSEL_48, 1'b1));
        pending_reqs.push_back(make_req('1, 64'h8000_0000_0000_0000, 1'b1,
                                        abna_pkg::WSEL_64, 1'b0));
        pending_reqs.push_back(make_req(64'h0000_0A00_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_48, 1'b0));
        pending_reqs.push_back(make_req(64'h0000_0E00_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_48, 1'b1));
        pending_reqs.push_back(make_req(64'h0000_0300_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_48, 1'b0));
        pending_reqs.push_back(make_req(64'h0A00_0000_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_64, 1'b0));
        pending_reqs.push_back(make_req(64'h0F00_0000_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_64, 1'b1));
        pending_reqs.push_back(make_req(64'h0300_0000_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_AUTO, 1'b0));
        pending_reqs.push_back(make_req(64'h0000_0400_0000_0000, 64'd1, 1'b0,
                                        abna_pkg::WSEL_48, 1'b0));
        pending_reqs.push_back(make_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                        1'b0, 2'd3, 1'b1));
        wait_drained();

        // long receiver hold while the sender keeps offering
        hold_sink = 1'b1;
        for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req());
        repeat (200) @(posedge i_clk);
        hold_sink = 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_reqs.push_back(rand_req());
            if (i == RANDOM_ITEMS / 2) begin
                // sender pauses until all results are back
                wait_drained();
            end
        end
        while (pending_reqs.size() > 200) @(posedge i_clk);
        quiet_mode = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results, %0d empty count sets",
                 accepted_in, accepted_out, empty_seen);
        $display("with corner bases, prefix and random masks, all width selects and stalls");
        if (mismatch_count == 0 && expected_blocks.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
